@@ design/crs_pkg.sv @@
// Shared types and constants for the Catmull-Rom spline sampler.
// No dependencies; used by crs_ctrl, crs_dp and the top level.
package crs_pkg;

  localparam int unsigned COORD_BITS = 16;

  // sample count register: 5 bits, 0 acts as 1
  localparam int unsigned  SCNT_W     = 5;
  localparam logic [SCNT_W-1:0] SCNT_RESET = 5'd16;

  // Bernstein weight width: 6*31^3 < 2^18
  localparam int unsigned WGT_W = 18;
  // divisor 12*S^3 width
  localparam int unsigned DIV_W = WGT_W + 1;

  typedef struct packed {
    logic              cap_in;     // capture the accepted point
    logic              load_pts;   // load the four control points
    logic              seg_final;  // closing segment with end point doubled
    logic              pm_dup;     // first segment: missing neighbour doubled
    logic              st_w1;      // squares and neighbour combinations
    logic              st_w2;      // cubic weights and divisor
    logic              st_mul;     // weight products
    logic              st_sum;     // numerator sum
    logic              div_ld;     // round, fold sign, start divider
    logic              div_run;    // one quotient bit
    logic              out_wr;     // write the output register
    logic              out_pt;     // output a point instead of a sample
    logic              pt_input;   // point is the captured input, else newest held
    logic              out_last;
    logic              win_shift;
    logic [SCNT_W-1:0] s_idx;
    logic [SCNT_W-1:0] sc;
  } crs_cmd_t;

endpackage

@@ design/crs_div.sv @@
// Restoring divider, one quotient bit per cycle while run_i is high, unsigned operands.
// No package dependency; instantiated by crs_dp.
module crs_div #(
  parameter int unsigned MW = 40,
  parameter int unsigned QW = 17,
  parameter int unsigned DW = 19
) (
  input  logic          clk_i,
  input  logic          ld_i,
  input  logic          run_i,
  input  logic [MW-1:0] m_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] quot_o
);

  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] sh_q, sh_d;
  logic [DW:0]   trial, diff;
  logic          ge;

  // the quotient is known to fit QW bits, so the top of m is already below d
  always_comb begin
    trial = {rem_q, sh_q[QW-1]};
    diff  = trial - {1'b0, d_i};
    ge    = (trial >= {1'b0, d_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    sh_d  = {sh_q[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      rem_q <= m_i[QW+DW-1:QW];
      sh_q  <= m_i[QW-1:0];
    end else if (run_i) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign quot_o = sh_q;

endmodule

@@ design/crs_dp.sv @@
// Datapath: point window, Bezier weight pipeline, two dividers, output register.
// Depends on crs_pkg (command struct, widths) and crs_div.
module crs_dp #(
  parameter int unsigned CB = crs_pkg::COORD_BITS
) (
  input  logic                   clk_i,
  input  crs_pkg::crs_cmd_t      cmd_i,
  input  logic signed [CB-1:0]   point_x_i,
  input  logic signed [CB-1:0]   point_y_i,
  output logic signed [CB-1:0]   sample_x_o,
  output logic signed [CB-1:0]   sample_y_o,
  output logic                   last_sample_o
);

  localparam int unsigned SW = crs_pkg::SCNT_W;
  localparam int unsigned WW = crs_pkg::WGT_W;
  localparam int unsigned DW = crs_pkg::DIV_W;
  localparam int unsigned CW = CB + 3;        // 6*p1 + p2 - p0
  localparam int unsigned PW = CW + WW + 1;   // signed product
  localparam int unsigned NW = PW + 2;        // sum of four products
  localparam int unsigned QW = CB + 1;        // quotient magnitude

  localparam logic signed [QW:0] QMAX = $signed({3'b000, {(CB-1){1'b1}}});
  localparam logic signed [QW:0] QMIN = $signed({3'b111, {(CB-1){1'b0}}});

  logic signed [CB-1:0] pin_q [2];
  logic signed [CB-1:0] win_q [2][3];
  logic signed [CB-1:0] pts_q [2][4];
  logic signed [CB-1:0] pts_d [2][4];
  logic signed [CW-1:0] ext_w [2][4];
  logic signed [CW-1:0] ca_q [2];
  logic signed [CW-1:0] cb_q [2];
  logic signed [CW-1:0] ca_d [2];
  logic signed [CW-1:0] cb_d [2];
  logic [2*SW-1:0]      aa_q, bb_q, ss_q;
  logic [SW-1:0]        a_w;
  logic [WW-1:0]        w_q [4];
  logic [WW-1:0]        w_d [4];
  logic [WW-1:0]        d6_q, d6_d;
  logic signed [PW-1:0] pr_q [2][4];
  logic signed [PW-1:0] pr_d [2][4];
  logic signed [NW-1:0] num_q [2];
  logic signed [NW-1:0] num_d [2];
  logic signed [NW:0]   n2_w [2];
  logic [NW-1:0]        m_w [2];
  logic                 neg_q [2];
  logic [QW-1:0]        uq_w [2];
  logic signed [QW:0]   q_w [2];
  logic signed [CB-1:0] sat_w [2];
  logic signed [CB-1:0] pt_w [2];
  logic signed [CB-1:0] ox_q, oy_q;
  logic                 ol_q;

  assign a_w = cmd_i.sc - cmd_i.s_idx;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (cmd_i.seg_final) begin
        pts_d[c][0] = win_q[c][1];
        pts_d[c][1] = win_q[c][2];
        pts_d[c][2] = pin_q[c];
        pts_d[c][3] = pin_q[c];
      end else begin
        pts_d[c][0] = cmd_i.pm_dup ? win_q[c][1] : win_q[c][0];
        pts_d[c][1] = win_q[c][1];
        pts_d[c][2] = win_q[c][2];
        pts_d[c][3] = pin_q[c];
      end
      for (int k = 0; k < 4; k++) begin
        ext_w[c][k] = $signed({{3{pts_q[c][k][CB-1]}}, pts_q[c][k]});
      end
      ca_d[c] = (ext_w[c][1] <<< 2) + (ext_w[c][1] <<< 1) + ext_w[c][2] - ext_w[c][0];
      cb_d[c] = (ext_w[c][2] <<< 2) + (ext_w[c][2] <<< 1) + ext_w[c][1] - ext_w[c][3];
    end
  end

  // weights 6a^3, 3a^2b, 3ab^2, 6b^3 with a = S - s, b = s; divisor base 6S^3
  always_comb begin
    w_d[0] = WW'(aa_q) * WW'(a_w) * WW'(6);
    w_d[1] = WW'(aa_q) * WW'(cmd_i.s_idx) * WW'(3);
    w_d[2] = WW'(bb_q) * WW'(a_w) * WW'(3);
    w_d[3] = WW'(bb_q) * WW'(cmd_i.s_idx) * WW'(6);
    d6_d   = WW'(ss_q) * WW'(cmd_i.sc) * WW'(6);
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      pr_d[c][0] = $signed({{(PW-CB){pts_q[c][1][CB-1]}}, pts_q[c][1]})
                 * $signed({{(PW-WW){1'b0}}, w_q[0]});
      pr_d[c][1] = $signed({{(PW-CW){ca_q[c][CW-1]}}, ca_q[c]})
                 * $signed({{(PW-WW){1'b0}}, w_q[1]});
      pr_d[c][2] = $signed({{(PW-CW){cb_q[c][CW-1]}}, cb_q[c]})
                 * $signed({{(PW-WW){1'b0}}, w_q[2]});
      pr_d[c][3] = $signed({{(PW-CB){pts_q[c][2][CB-1]}}, pts_q[c][2]})
                 * $signed({{(PW-WW){1'b0}}, w_q[3]});
      num_d[c] = $signed({{2{pr_q[c][0][PW-1]}}, pr_q[c][0]})
               + $signed({{2{pr_q[c][1][PW-1]}}, pr_q[c][1]})
               + $signed({{2{pr_q[c][2][PW-1]}}, pr_q[c][2]})
               + $signed({{2{pr_q[c][3][PW-1]}}, pr_q[c][3]});
      // round to nearest, ties up: floor((2N + D) / 2D); negative folded as ~
      n2_w[c] = $signed({num_q[c], 1'b0}) + $signed({{(NW+1-WW){1'b0}}, d6_q});
      m_w[c]  = n2_w[c][NW] ? ~n2_w[c][NW-1:0] : n2_w[c][NW-1:0];
      q_w[c]  = neg_q[c] ? ~$signed({1'b0, uq_w[c]}) : $signed({1'b0, uq_w[c]});
      if (q_w[c] > QMAX) begin
        sat_w[c] = QMAX[CB-1:0];
      end else if (q_w[c] < QMIN) begin
        sat_w[c] = QMIN[CB-1:0];
      end else begin
        sat_w[c] = q_w[c][CB-1:0];
      end
      pt_w[c] = cmd_i.pt_input ? pin_q[c] : win_q[c][2];
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_div
    crs_div #(
      .MW(NW),
      .QW(QW),
      .DW(DW)
    ) u_div (
      .clk_i (clk_i),
      .ld_i  (cmd_i.div_ld),
      .run_i (cmd_i.div_run),
      .m_i   (m_w[g]),
      .d_i   ({d6_q, 1'b0}),
      .quot_o(uq_w[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      pin_q[0] <= point_x_i;
      pin_q[1] <= point_y_i;
    end
    for (int c = 0; c < 2; c++) begin
      if (cmd_i.win_shift) begin
        win_q[c][0] <= win_q[c][1];
        win_q[c][1] <= win_q[c][2];
        win_q[c][2] <= pin_q[c];
      end
      if (cmd_i.load_pts) begin
        for (int k = 0; k < 4; k++) begin
          pts_q[c][k] <= pts_d[c][k];
        end
      end
      if (cmd_i.st_w1) begin
        ca_q[c] <= ca_d[c];
        cb_q[c] <= cb_d[c];
      end
      if (cmd_i.st_mul) begin
        for (int k = 0; k < 4; k++) begin
          pr_q[c][k] <= pr_d[c][k];
        end
      end
      if (cmd_i.st_sum) begin
        num_q[c] <= num_d[c];
      end
      if (cmd_i.div_ld) begin
        neg_q[c] <= n2_w[c][NW];
      end
    end
    if (cmd_i.st_w1) begin
      aa_q <= (2*SW)'(a_w) * (2*SW)'(a_w);
      bb_q <= (2*SW)'(cmd_i.s_idx) * (2*SW)'(cmd_i.s_idx);
      ss_q <= (2*SW)'(cmd_i.sc) * (2*SW)'(cmd_i.sc);
    end
    if (cmd_i.st_w2) begin
      for (int k = 0; k < 4; k++) begin
        w_q[k] <= w_d[k];
      end
      d6_q <= d6_d;
    end
    if (cmd_i.out_wr) begin
      ox_q <= cmd_i.out_pt ? pt_w[0] : sat_w[0];
      oy_q <= cmd_i.out_pt ? pt_w[1] : sat_w[1];
      ol_q <= cmd_i.out_last;
    end
  end

  assign sample_x_o    = ox_q;
  assign sample_y_o    = oy_q;
  assign last_sample_o = ol_q;

endmodule

@@ design/crs_ctrl.sv @@
// Controller: point sequencing, sample loop, divider count, output valid.
// Depends on crs_pkg; drives crs_dp through crs_cmd_t.
module crs_ctrl #(
  parameter int unsigned QUOT_W = crs_pkg::COORD_BITS + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          last_point_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          cfg_we_i,
  input  logic [crs_pkg::SCNT_W-1:0]    cfg_wdata_i,
  output crs_pkg::crs_cmd_t             cmd_o
);

  localparam int unsigned SW    = crs_pkg::SCNT_W;
  localparam int unsigned CNT_W = $clog2(QUOT_W);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SEL  = 4'd1;
  localparam logic [3:0] ST_W1   = 4'd2;
  localparam logic [3:0] ST_W2   = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_SUM  = 4'd5;
  localparam logic [3:0] ST_LD   = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;
  localparam logic [3:0] ST_PUT  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [1:0]       seen_q, seen_d;
  logic             last_q, last_d;
  logic             final_q, final_d;
  logic             put_q, put_d;
  logic [SW-1:0]    s_q, s_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SW-1:0]    cfg_q;
  logic [SW-1:0]    sc;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             in_fire;

  assign sc         = (cfg_q == '0) ? SW'(1) : cfg_q;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    last_d  = last_q;
    final_d = final_q;
    put_d   = put_q;
    s_d     = s_q;
    cnt_d   = cnt_q;

    cmd_o           = '0;
    cmd_o.sc        = sc;
    cmd_o.s_idx     = s_q;
    cmd_o.seg_final = final_q;
    cmd_o.pm_dup    = (seen_q == 2'd2);
    cmd_o.pt_input  = put_q;
    cmd_o.cap_in    = in_fire;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          last_d = last_point_i;
          if (seen_q inside {2'd2, 2'd3}) begin
            final_d = 1'b0;
            state_d = ST_SEL;
          end else if (seen_q == 2'd1 && last_point_i) begin
            put_d   = 1'b0;
            state_d = ST_PUT;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SEL: begin
        cmd_o.load_pts = 1'b1;
        s_d            = '0;
        state_d        = ST_W1;
      end
      ST_W1: begin
        cmd_o.st_w1 = 1'b1;
        state_d     = ST_W2;
      end
      ST_W2: begin
        cmd_o.st_w2 = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.st_mul = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.st_sum = 1'b1;
        state_d      = ST_LD;
      end
      ST_LD: begin
        cmd_o.div_ld = 1'b1;
        cnt_d        = '0;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_wr = 1'b1;
          if (s_q == sc - SW'(1)) begin
            if (!last_q) begin
              state_d = ST_FIN;
            end else if (!final_q) begin
              final_d = 1'b1;
              state_d = ST_SEL;
            end else begin
              put_d   = 1'b1;
              state_d = ST_PUT;
            end
          end else begin
            s_d     = s_q + SW'(1);
            state_d = ST_W1;
          end
        end
      end
      ST_PUT: begin
        if (out_free) begin
          cmd_o.out_wr   = 1'b1;
          cmd_o.out_pt   = 1'b1;
          cmd_o.out_last = put_q;
          if (put_q) begin
            state_d = ST_FIN;
          end else begin
            put_d = 1'b1;
          end
        end
      end
      ST_FIN: begin
        // end of line empties the window; otherwise the new point moves in
        if (last_q) begin
          seen_d = 2'd0;
        end else begin
          cmd_o.win_shift = 1'b1;
          seen_d          = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = cmd_o.out_wr ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= 2'd0;
      last_q      <= 1'b0;
      final_q     <= 1'b0;
      put_q       <= 1'b0;
      s_q         <= '0;
      cnt_q       <= '0;
      cfg_q       <= crs_pkg::SCNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      last_q      <= last_d;
      final_q     <= final_d;
      put_q       <= put_d;
      s_q         <= s_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_wr |-> (!out_valid_q || out_ready_i))
    else $error("output register written while a request is still held");

  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && last_q) |=> (seen_q == 2'd0 && state_q == ST_IDLE))
    else $error("window count not cleared at end of line");

  a_sample_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (s_q < sc))
    else $error("sample index beyond segment length");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("new point taken before the previous one finished");

endmodule

@@ design/catmull_rom_spline_sampler.sv @@
// Catmull-Rom spline sampler: one point at a time, S samples per segment.
// Each sample passes the weight pipeline of five stages, the divider (one quotient bit a cycle)
// and one output write. A point opening a segment gives S samples, the last point of a line two
// segments and the end point, the end of a two-point line both points, other points nothing.
// An output stall holds the sampler until the request is taken. Asynchronous active-low reset:
// empty window, no request pending, sample count 16.
module catmull_rom_spline_sampler #(
  parameter int unsigned COORD_BITS = crs_pkg::COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic                          last_point_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS-1:0]  sample_x_o,
  output logic signed [COORD_BITS-1:0]  sample_y_o,
  output logic                          last_sample_o,
  input  logic                          cfg_we_i,
  input  logic [crs_pkg::SCNT_W-1:0]    cfg_wdata_i
);

  crs_pkg::crs_cmd_t cmd;

  crs_ctrl #(
    .QUOT_W(COORD_BITS + 1)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_point_i(last_point_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd)
  );

  crs_dp #(
    .CB(COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .sample_x_o   (sample_x_o),
    .sample_y_o   (sample_y_o),
    .last_sample_o(last_sample_o)
  );

endmodule
